>>> sv/bpc_pkg.sv
// Package with the shared types and constants of the button press classifier.
package bpc_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_W       = 2;
    localparam int TIME_W      = 16;
    localparam int CFG_W       = 64;
    localparam int ADDR_W      = 5;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int MAX_EVENTS  = 3;
    localparam int EV_CNT_W    = 2;

    typedef enum logic [1:0] {
        ST_UNPRESSED = 2'd0,
        ST_PRESSED   = 2'd1,
        ST_LONG      = 2'd2
    } press_state_t;

    typedef enum logic [1:0] {
        EV_PRESSED   = 2'd0,
        EV_LONG      = 2'd1,
        EV_RELEASED  = 2'd2,
        EV_UNPRESSED = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        REG_PRESS_THR = 2'd0,
        REG_LONG_THR  = 2'd1,
        REG_IDLE_LVL  = 2'd2,
        REG_NOTIFY    = 2'd3
    } reg_index_t;

    // All events caused by one tick, drained one per output transaction.
    typedef struct packed {
        logic [BTN_W-1:0]    button;
        logic [EV_CNT_W-1:0] count;
        event_kind_t         kind0;
        event_kind_t         kind1;
        event_kind_t         kind2;
    } evt_rec_t;

endpackage

>>> sv/button_press_classifier_top.sv
// Top level of the button press classifier: tick stage, press state and event queue.
//
// The block classifies presses of up to four buttons. Each input transaction is one tick
// for one button (index, sampled level, milliseconds since its previous tick). A button is
// held while its level differs from its configured idle level; its 16-bit hold timer then
// accumulates (saturating) and the button steps from unpressed to pressed to long pressed
// as its thresholds are reached, one step per tick. A tick at idle level clears the timer
// and, for a button with its notify bit set, reports released then unpressed, possibly
// followed by pressed when the press threshold is zero. Each tick yields zero to three
// output transactions, the final one marked with m_tlast. A tick is captured in an input
// register and classified from it once the queue has room; then the per-button state is
// updated and the tick's events, if any, are pushed as one record into a four-entry queue.
// One tick per cycle is taken while the queue has room; the queue drains one event per
// cycle while the consumer is ready, so eventful ticks go at the event consumer's pace.
// Registers are written over an APB-style port at byte addresses 0, 8, 16 and 24; the user
// must change configuration only while idle, as the block itself does not enforce it.
module button_press_classifier_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // Tick input. s_tdata: button [1:0], level [2], elapsed_ms [18:3], zeros above.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,
    // Event output. m_tdata: event_button [1:0], event_kind [3:2], zeros above.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::CFG_W-1:0]   pwdata,
    output logic [bpc_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);
    import bpc_pkg::*;

    // ---------------------------------------------------------------- registers
    logic [CFG_W-1:0]       press_thr_reg;
    logic [CFG_W-1:0]       long_thr_reg;
    logic [NUM_BUTTONS-1:0] idle_lvl_reg;
    logic [NUM_BUTTONS-1:0] notify_reg;

    reg_index_t cfg_sel;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = reg_index_t'(paddr[ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_thr_reg <= '0;
            long_thr_reg  <= '0;
            idle_lvl_reg  <= '0;
            notify_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_PRESS_THR: press_thr_reg <= pwdata;
                REG_LONG_THR:  long_thr_reg  <= pwdata;
                REG_IDLE_LVL:  idle_lvl_reg  <= pwdata[NUM_BUTTONS-1:0];
                REG_NOTIFY:    notify_reg    <= pwdata[NUM_BUTTONS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_sel)
            REG_PRESS_THR: prdata = press_thr_reg;
            REG_LONG_THR:  prdata = long_thr_reg;
            REG_IDLE_LVL:  prdata[NUM_BUTTONS-1:0] = idle_lvl_reg;
            REG_NOTIFY:    prdata[NUM_BUTTONS-1:0] = notify_reg;
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- tick input register
    logic              in_vld_reg;
    logic [BTN_W-1:0]  in_btn_reg;
    logic              in_lvl_reg;
    logic [TIME_W-1:0] in_ms_reg;
    logic              consume;
    logic              q_full;

    // The registered tick is retired whenever the queue can take its record.
    assign consume  = in_vld_reg && !q_full;
    assign s_tready = !in_vld_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_btn_reg <= s_tdata[BTN_W-1:0];
            in_lvl_reg <= s_tdata[BTN_W];
            in_ms_reg  <= s_tdata[BTN_W+1 +: TIME_W];
        end
    end

    // ---------------------------------------------------------------- classification
    press_state_t      press_state_reg [NUM_BUTTONS];
    logic [TIME_W-1:0] held_time_reg   [NUM_BUTTONS];

    logic              btn_ok;
    press_state_t      st_cur;
    press_state_t      st_next;
    logic [TIME_W-1:0] ht_cur;
    logic [TIME_W-1:0] ht_next;
    logic [TIME_W:0]   ht_sum;
    logic [TIME_W-1:0] pth;
    logic [TIME_W-1:0] lth;
    logic              notify;
    logic              check;
    evt_rec_t          rec_next;

    assign btn_ok = ({1'b0, in_btn_reg} < (BTN_W+1)'(NUM_BUTTONS));
    assign pth    = press_thr_reg[TIME_W*in_btn_reg +: TIME_W];
    assign lth    = long_thr_reg[TIME_W*in_btn_reg +: TIME_W];
    assign notify = notify_reg[in_btn_reg];
    assign ht_cur = held_time_reg[in_btn_reg];
    assign ht_sum = {1'b0, ht_cur} + {1'b0, in_ms_reg};

    always_comb
    begin
        st_cur = press_state_reg[in_btn_reg];
        // The unused state code behaves as unpressed.
        if (st_cur != ST_PRESSED && st_cur != ST_LONG)
        begin
            st_cur = ST_UNPRESSED;
        end
        st_next         = st_cur;
        check           = 1'b1;
        rec_next        = '0;
        rec_next.button = in_btn_reg;
        rec_next.kind0  = EV_PRESSED;
        rec_next.kind1  = EV_PRESSED;
        rec_next.kind2  = EV_PRESSED;

        if (in_lvl_reg != idle_lvl_reg[in_btn_reg])
        begin
            ht_next = ht_sum[TIME_W] ? '1 : ht_sum[TIME_W-1:0];
        end
        else
        begin
            ht_next = '0;
            if (st_cur != ST_UNPRESSED)
            begin
                st_next = ST_UNPRESSED;
                if (notify)
                begin
                    rec_next.kind0 = EV_RELEASED;
                    rec_next.kind1 = EV_UNPRESSED;
                    rec_next.count = EV_CNT_W'(2);
                end
                else
                begin
                    check = 1'b0;
                end
            end
        end

        if (check)
        begin
            unique case (st_next)
                ST_UNPRESSED:
                begin
                    if (ht_next >= pth)
                    begin
                        st_next = ST_PRESSED;
                        if (notify)
                        begin
                            // Lands after released and unpressed when those came first.
                            if (rec_next.count == '0)
                            begin
                                rec_next.kind0 = EV_PRESSED;
                            end
                            else
                            begin
                                rec_next.kind2 = EV_PRESSED;
                            end
                            rec_next.count = rec_next.count + EV_CNT_W'(1);
                        end
                    end
                end
                ST_PRESSED:
                begin
                    if (ht_next >= lth)
                    begin
                        st_next = ST_LONG;
                        if (notify)
                        begin
                            rec_next.kind0 = EV_LONG;
                            rec_next.count = EV_CNT_W'(1);
                        end
                    end
                end
                ST_LONG:
                begin
                    ht_next = lth;
                end
                default:
                begin
                    st_next = ST_UNPRESSED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                press_state_reg[i] <= ST_UNPRESSED;
                held_time_reg[i]   <= '0;
            end
        end
        else if (consume && btn_ok)
        begin
            press_state_reg[in_btn_reg] <= st_next;
            held_time_reg[in_btn_reg]   <= ht_next;
        end
    end

    // ---------------------------------------------------------------- event queue
    evt_rec_t            q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  q_wr_reg;
    logic [Q_PTR_W-1:0]  q_rd_reg;
    logic [Q_CNT_W-1:0]  q_cnt_reg;
    logic [EV_CNT_W-1:0] sub_reg;
    logic                push;
    logic                pop_ev;
    logic                pop_rec;
    evt_rec_t            head;
    event_kind_t         head_kind;

    assign q_full   = (q_cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign push     = consume && btn_ok && (rec_next.count != '0);
    assign head     = q_mem[q_rd_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tlast  = (sub_reg == head.count - EV_CNT_W'(1));
    assign pop_ev   = m_tvalid && m_tready;
    assign pop_rec  = pop_ev && m_tlast;

    always_comb
    begin
        unique case (sub_reg)
            2'd0:    head_kind = head.kind0;
            2'd1:    head_kind = head.kind1;
            default: head_kind = head.kind2;
        endcase
    end

    assign m_tdata = {4'b0, head_kind, head.button};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[q_wr_reg] <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wr_reg <= q_wr_reg + Q_PTR_W'(1);
            end
            if (pop_rec)
            begin
                q_rd_reg <= q_rd_reg + Q_PTR_W'(1);
                sub_reg  <= '0;
            end
            else if (pop_ev)
            begin
                sub_reg <= sub_reg + EV_CNT_W'(1);
            end
            if (push && !pop_rec)
            begin
                q_cnt_reg <= q_cnt_reg + Q_CNT_W'(1);
            end
            else if (pop_rec && !push)
            begin
                q_cnt_reg <= q_cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------- assertions
    a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("event queue count above its depth");

    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sub_reg < head.count))
        else $error("event index beyond the events of the head record");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop_rec |=> (sub_reg == '0))
        else $error("event index not restarted after the final event of a tick");

    a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && q_full) |=> (in_vld_reg && $stable(in_btn_reg) && $stable(in_ms_reg)))
        else $error("registered tick lost while the queue was full");

endmodule

>>> tb/sv/button_press_classifier_top_test.sv
// Self-checking testbench for the button press classifier: stream ticks in, check events out.
`timescale 1ns / 100ps

module button_press_classifier_top_test;
    import bpc_pkg::*;

    // Keeps a private copy of the per-button press state and the register settings.
    // Every accepted tick is classified here, and the events it should cause are queued.
    class press_event_board;

        typedef struct packed {
            logic [BTN_W-1:0] btn;
            event_kind_t      kind;
            logic             last;
        } press_event_t;

        logic [CFG_W-1:0]       press_thr;
        logic [CFG_W-1:0]       long_thr;
        logic [NUM_BUTTONS-1:0] idle_lvl;
        logic [NUM_BUTTONS-1:0] notify_en;
        press_state_t           btn_state[NUM_BUTTONS];
        logic [TIME_W-1:0]      held_ms[NUM_BUTTONS];
        press_event_t           expected_events[$];
        int                     mismatches;

        function new();
            press_thr  = '0;
            long_thr   = '0;
            idle_lvl   = '0;
            notify_en  = '0;
            mismatches = 0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                btn_state[i] = ST_UNPRESSED;
                held_ms[i]   = '0;
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PRESS_THR: press_thr = value;
                REG_LONG_THR:  long_thr  = value;
                REG_IDLE_LVL:  idle_lvl  = value[NUM_BUTTONS-1:0];
                default:       notify_en = value[NUM_BUTTONS-1:0];
            endcase
        endfunction

        // Applies one tick to the button's state and queues the events it reports.
        function void classify_tick(logic [BTN_W-1:0] btn, logic lvl, logic [TIME_W-1:0] ms);
            logic [TIME_W-1:0] pth;
            logic [TIME_W-1:0] lth;
            logic [TIME_W:0]   sum;
            press_state_t      st;
            event_kind_t       kinds[$];
            logic              notify;
            logic              upgrade_ok;
            press_event_t      ev;

            pth        = press_thr[{btn, 4'd0} +: TIME_W];
            lth        = long_thr[{btn, 4'd0} +: TIME_W];
            st         = btn_state[btn];
            notify     = notify_en[btn];
            upgrade_ok = 1'b1;

            if (lvl != idle_lvl[btn])
            begin
                sum          = {1'b0, held_ms[btn]} + {1'b0, ms};
                held_ms[btn] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end
            else
            begin
                held_ms[btn] = '0;
                if (st != ST_UNPRESSED)
                begin
                    st = ST_UNPRESSED;
                    if (notify)
                    begin
                        kinds.push_back(EV_RELEASED);
                        kinds.push_back(EV_UNPRESSED);
                    end
                    else
                    begin
                        // A silent button leaving a press skips the upgrade check.
                        upgrade_ok = 1'b0;
                    end
                end
            end

            if (upgrade_ok)
            begin
                case (st)
                    ST_UNPRESSED:
                    begin
                        if (held_ms[btn] >= pth)
                        begin
                            st = ST_PRESSED;
                            if (notify)
                            begin
                                kinds.push_back(EV_PRESSED);
                            end
                        end
                    end
                    ST_PRESSED:
                    begin
                        if (held_ms[btn] >= lth)
                        begin
                            st = ST_LONG;
                            if (notify)
                            begin
                                kinds.push_back(EV_LONG);
                            end
                        end
                    end
                    default:
                    begin
                        held_ms[btn] = lth;
                    end
                endcase
            end

            btn_state[btn] = st;
            foreach (kinds[i])
            begin
                ev.btn  = btn;
                ev.kind = kinds[i];
                ev.last = (i == kinds.size() - 1);
                expected_events.push_back(ev);
            end
        endfunction

        function void check_event(logic [BTN_W-1:0] btn, logic [1:0] kind, logic last);
            press_event_t want;

            if (expected_events.size() == 0)
            begin
                report($sformatf("unexpected event: button %0d kind %0d last %0b",
                                 btn, kind, last));
                return;
            end
            want = expected_events.pop_front();
            if (btn !== want.btn || kind !== want.kind || last !== want.last)
            begin
                report($sformatf("expected button %0d kind %s last %0b, got button %0d kind %0d last %0b",
                                 want.btn, want.kind.name(), want.last, btn, kind, last));
            end
        endfunction

    endclass

    // Cycles allowed after the last expected event for ticks that report nothing to
    // leave the input register and the classify stage.
    localparam int DRAIN_CYCLES = 10;
    // Length of the one long receiver stall that backs the event queue up.
    localparam int HOLD_CYCLES  = 60;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;   // button [1:0], level [2], elapsed_ms [18:3], zeros above
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;   // event_button [1:0], event_kind [3:2], zeros above
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    press_event_board   board;

    // Sender pacing: a burst counter, and a switch that keeps tvalid up with no gaps.
    int                 burst_left = 0;
    bit                 no_gaps = 1'b0;
    // Set by the stimulus to ask the receiver for its long stall.
    bit                 hold_request = 1'b0;

    button_press_classifier_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one tick and waits for its transaction. Unless no_gaps is set, ticks go out in
    // bursts of random length and tvalid drops between bursts. The tick is handed to the
    // scoreboard in the same step its transaction completes, so the count of pending
    // events is never behind the block.
    task automatic send_tick(input logic [BTN_W-1:0] btn, input logic lvl,
                             input logic [TIME_W-1:0] ms);
        if (burst_left == 0 && !no_gaps)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, ms, lvl, btn};
        do
            @(posedge clk);
        while (!s_tready);
        board.classify_tick(btn, lvl, ms);
    endtask

    // Stops the sender and waits until every expected event has arrived, then lets the
    // pipeline empty of ticks that cause no event.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB write (setup and access), then a read of the same register to confirm it.
    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] want;

        want = (idx == REG_IDLE_LVL || idx == REG_NOTIFY) ? {60'd0, value[3:0]} : value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            board.report($sformatf("register %s read back %h, expected %h",
                                   idx.name(), prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, value);
        @(posedge clk);
    endtask

    // Waits for the block to go quiet, then loads all four registers.
    task automatic configure(input logic [CFG_W-1:0] pth, input logic [CFG_W-1:0] lth,
                             input logic [3:0] idle, input logic [3:0] notify);
        wait_idle();
        write_reg(REG_PRESS_THR, pth);
        write_reg(REG_LONG_THR, lth);
        write_reg(REG_IDLE_LVL, {60'd0, idle});
        write_reg(REG_NOTIFY, {60'd0, notify});
    endtask

    // Random per-button thresholds. When ordered, each long threshold lies above its
    // press threshold; otherwise the two are independent and may be in either order.
    task automatic pick_thresholds(output logic [CFG_W-1:0] pth, output logic [CFG_W-1:0] lth,
                                   input int max_ms, input bit ordered);
        int p;
        int l;

        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            p = $urandom_range(0, max_ms);
            l = ordered ? p + $urandom_range(1, max_ms) : $urandom_range(0, max_ms);
            if (l > 65535)
            begin
                l = 65535;
            end
            pth[16*i +: 16] = p[15:0];
            lth[16*i +: 16] = l[15:0];
        end
    endtask

    function automatic logic [TIME_W-1:0] pick_ms(input int step_ms);
        if ($urandom_range(0, 9) == 0)
        begin
            return TIME_W'($urandom_range(0, 65535));
        end
        return TIME_W'($urandom_range(0, step_ms));
    endfunction

    // Mostly well-formed presses: a run of held ticks on one button, usually closed by a
    // tick at idle level. The rest are ticks with fully random content.
    task automatic run_random(input int n_items, input int step_ms);
        int               sent;
        int               len;
        logic [BTN_W-1:0] btn;
        logic             idle;

        sent = 0;
        while (sent < n_items)
        begin
            btn  = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
            idle = board.idle_lvl[btn];
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    send_tick(btn, ~idle, pick_ms(step_ms));
                end
                sent += len;
                if ($urandom_range(0, 4) != 0)
                begin
                    send_tick(btn, idle, pick_ms(step_ms));
                    sent++;
                end
            end
            else
            begin
                send_tick(btn, 1'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 65535)));
                sent++;
            end
        end
    endtask

    // The receiver runs through random modes (always ready, coin toss, mostly stalled).
    // On request it holds tready low for one long stretch so that the event
    // queue fills and the block has to stall its tick input.
    initial
    begin : receiver
        int mode;
        int span;
        int hold;

        mode     = 0;
        span     = 0;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(20, 150);
                end
                span--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Every event transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_event(m_tdata[1:0], m_tdata[3:2], m_tlast);
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] pth;
        logic [CFG_W-1:0] lth;

        board    = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Button 0 idles high with thresholds 20/60, button 1 idles low
        // with its long threshold below its press threshold, button 2 is silent with
        // both thresholds at the top, button 3 has a press threshold of zero.
        configure({16'd0, 16'hFFFF, 16'd100, 16'd20}, {16'd5, 16'hFFFF, 16'd50, 16'd60},
                  4'b0101, 4'b1011);
        send_tick(2'd0, 1'b0, 16'd10);      // held, below the press threshold
        send_tick(2'd0, 1'b0, 16'd15);      // pressed
        send_tick(2'd0, 1'b0, 16'd40);      // long pressed
        send_tick(2'd0, 1'b0, 16'hFFFF);    // timer saturates, then clamps to the long threshold
        send_tick(2'd0, 1'b1, 16'd0);       // released, unpressed
        send_tick(2'd3, 1'b0, 16'd0);       // idle tick still reports pressed at threshold zero
        send_tick(2'd3, 1'b0, 16'd7);       // released, unpressed, pressed in one tick
        send_tick(2'd3, 1'b1, 16'd3);       // held, below the long threshold
        send_tick(2'd3, 1'b1, 16'd2);       // long pressed exactly at the threshold
        send_tick(2'd1, 1'b1, 16'hFFFF);    // only one upgrade per tick: pressed
        send_tick(2'd1, 1'b1, 16'd0);       // long pressed on the next tick
        send_tick(2'd1, 1'b1, 16'd1);       // long pressed, timer clamped
        send_tick(2'd2, 1'b0, 16'hFFFF);    // silent press at the top threshold
        send_tick(2'd2, 1'b0, 16'hFFFF);    // silent long press with a saturated timer
        send_tick(2'd2, 1'b1, 16'd0);       // silent release skips the upgrade check
        send_tick(2'd2, 1'b1, 16'd100);     // idle tick, nothing happens
        send_tick(2'd1, 1'b0, 16'h8000);    // released, unpressed
        send_tick(2'd3, 1'b0, 16'h5555);    // released, unpressed, pressed again
        send_tick(2'd0, 1'b1, 16'hAAAA);    // idle tick on an unpressed button

        // All thresholds at zero: every tick on a notifying button reports something,
        // except a held tick on a button that is already long pressed.
        configure('0, '0, 4'h0, 4'hF);
        run_random(40, 50);

        // All thresholds at the top: only saturated timers reach them.
        configure('1, '1, 4'hF, 4'hF);
        run_random(30, 65535);

        // Small ordered thresholds. The receiver stalls for a long stretch while the
        // sender keeps tvalid up, so the queue fills and s_tready has to drop.
        pick_thresholds(pth, lth, 150, 1'b1);
        configure(pth, lth, 4'($urandom_range(0, 15)), 4'hF);
        hold_request = 1'b1;
        no_gaps = 1'b1;
        run_random(20, 60);
        no_gaps = 1'b0;
        run_random(30, 60);

        pick_thresholds(pth, lth, 300, 1'b1);
        configure(pth, lth, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        run_random(50, 100);

        // No button notifies: state still moves, nothing comes out.
        configure(pth, lth, 4'($urandom_range(0, 15)), 4'h0);
        run_random(25, 100);

        // Long thresholds may sit at or below the press thresholds.
        pick_thresholds(pth, lth, 200, 1'b0);
        configure(pth, lth, 4'($urandom_range(0, 15)), 4'hF);
        run_random(60, 80);

        // Full-range thresholds with large time steps.
        pick_thresholds(pth, lth, 65535, 1'b0);
        configure(pth, lth, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        run_random(50, 20000);

        wait_idle();
        board.mismatches += board.expected_events.size();
        if (board.mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // The slowest correct run (three events per tick, a receiver that is ready with
    // odds of one in four, sender gaps and the long stall) stays far below this limit.
    initial
    begin : watchdog
        #(2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> button_press_classifier_top.f
sv/bpc_pkg.sv
sv/button_press_classifier_top.sv
tb/sv/button_press_classifier_top_test.sv
